[rtl/vfa_pkg.sv]
// ----------------------------------------------------------------------------
// vfa_pkg
// Shared types, opcodes and helpers of the four-component fixed-point vector
// ALU: opcode enum, pipeline context records, saturation and magnitude helpers.
// ----------------------------------------------------------------------------
package vfa_pkg;

  // operation codes
  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_SCALE = 4'd2,
    OP_DIV   = 4'd3,
    OP_NEG   = 4'd4,
    OP_EQ    = 4'd5,
    OP_NE    = 4'd6,
    OP_DOT   = 4'd7,
    OP_LEN   = 4'd8,
    OP_LENSQ = 4'd9,
    OP_NORM  = 4'd10,
    OP_MAX   = 4'd11,
    OP_MIN   = 4'd12,
    OP_CROSS = 4'd13,
    OP_LERP  = 4'd14
  } op_t;

  localparam int LANES     = 4;
  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 32;

  localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] WORD_MIN = 32'h8000_0000;

  typedef logic [LANES-1:0][31:0] vec_t;

  // context of the first two stages
  typedef struct packed {
    op_t         op;
    vec_t        a;
    logic [31:0] s;
    logic [31:0] mm;
    logic        cmp;
  } front_t;

  // context carried down the square root and divide chains
  typedef struct packed {
    op_t         op;
    vec_t        vec;
    logic [31:0] s;
    logic [31:0] sc;
    logic        cmp;
    logic        ov;
  } ctx_t;

  // per-lane restoring divider state
  typedef struct packed {
    logic [63:0] rem;
    logic [32:0] d;
    logic [31:0] q;
    logic        neg;
    logic        dz;
    logic        big;
    logic        apos;
    logic        aneg;
  } dlane_t;

  typedef dlane_t [LANES-1:0] dvec_t;

  // saturate a wide signed value to 32 bits, flag in the top bit
  function automatic logic [32:0] sat_word(input logic signed [67:0] v);
    if (v > 68'sd2147483647) begin
      return {1'b1, WORD_MAX};
    end else if (v < -68'sd2147483648) begin
      return {1'b1, WORD_MIN};
    end else begin
      return {1'b0, v[31:0]};
    end
  endfunction

  // magnitude of a signed word as unsigned (smallest value maps to 2^31)
  function automatic logic [31:0] abs_word(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

endpackage

[rtl/vec4_fixed_point_alu.sv]
// ----------------------------------------------------------------------------
// vec4_fixed_point_alu
// Four-component signed fixed-point vector ALU with saturation.
// ----------------------------------------------------------------------------
// Fully pipelined: one item is accepted every cycle unless a result is held
// at the output, and each item passes through multiply, lane rounding, merge
// sum, 32 square-root stages, divider setup, 32 divider stages and the output
// register. Every opcode takes the same path, so results leave in order. The
// depth is set by the 32-step square root and the 32-step restoring divider
// that normalize and divide need; in_ready drops only while a finished result
// is held at the output.
module vec4_fixed_point_alu
  import vfa_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic        [3:0]  in_op,
  input  logic signed [31:0] in_ax,
  input  logic signed [31:0] in_ay,
  input  logic signed [31:0] in_az,
  input  logic signed [31:0] in_aw,
  input  logic signed [31:0] in_bx,
  input  logic signed [31:0] in_by,
  input  logic signed [31:0] in_bz,
  input  logic signed [31:0] in_bw,
  input  logic signed [31:0] in_scale,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_rx,
  output logic signed [31:0] out_ry,
  output logic signed [31:0] out_rz,
  output logic signed [31:0] out_rw,
  output logic signed [31:0] out_scalar_out,
  output logic               out_compare_true,
  output logic               out_overflow
);

  localparam int NSTG = 3 + SQ_STEPS + 1 + DIV_STEPS;
  localparam logic signed [67:0] HALF = 68'sd1 <<< (FRAC_BITS - 1);

  logic              adv;
  logic [NSTG-1:0]   vld_r;
  op_t               op_in;

  logic signed [31:0] la [LANES];
  logic signed [31:0] lb [LANES];
  logic signed [31:0] ca0 [LANES];
  logic signed [31:0] cb0 [LANES];
  logic signed [31:0] ca1 [LANES];
  logic signed [31:0] cb1 [LANES];
  logic signed [65:0] prod [LANES];
  logic        [31:0] lres [LANES];
  logic               lov  [LANES];

  logic signed [31:0] mx01, mx23, mn01, mn23, mx, mn;
  front_t             front_in, front1_r, front2_r;
  logic signed [66:0] p01_r, p23_r;

  logic signed [67:0] total;
  logic signed [67:0] dot_rnd;
  logic        [32:0] dot_sat;
  ctx_t               ctx3;
  logic        [63:0] sq3;
  ctx_t               ctx3_r;
  logic        [63:0] sq3_r;

  ctx_t               ctx_s [SQ_STEPS+1];
  logic        [63:0] rem_s [SQ_STEPS+1];
  logic        [63:0] res_s [SQ_STEPS+1];

  logic        [32:0] len;
  logic        [32:0] dmag;
  logic        [31:0] amag;
  ctx_t               ctx_d;
  dvec_t              dl_d;
  ctx_t               ctx_v [DIV_STEPS+1];
  dvec_t              dl_v  [DIV_STEPS+1];

  vec_t               fv;
  logic               fov;
  ctx_t               ctx_e;
  dvec_t              dl_e;

  logic               out_valid_r;
  vec_t               out_vec_r;
  logic        [31:0] out_sc_r;
  logic               out_cmp_r;
  logic               out_ov_r;

  // pipeline advances unless a result waits at the output
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign op_in    = op_t'(in_op);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NSTG-2:0], in_valid};
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  // lane operands, cross terms per lane (w lane gets zeros)
  always_comb begin
    la[0] = in_ax; la[1] = in_ay; la[2] = in_az; la[3] = in_aw;
    lb[0] = in_bx; lb[1] = in_by; lb[2] = in_bz; lb[3] = in_bw;
    ca0[0] = in_ay; cb0[0] = in_bz; ca1[0] = in_az; cb1[0] = in_by;
    ca0[1] = in_az; cb0[1] = in_bx; ca1[1] = in_ax; cb1[1] = in_bz;
    ca0[2] = in_ax; cb0[2] = in_by; ca1[2] = in_ay; cb1[2] = in_bx;
    ca0[3] = '0;    cb0[3] = '0;    ca1[3] = '0;    cb1[3] = '0;
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    vfa_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .en     (adv),
      .op     (op_in),
      .a      (la[g]),
      .b      (lb[g]),
      .s      (in_scale),
      .ca0    (ca0[g]),
      .cb0    (cb0[g]),
      .ca1    (ca1[g]),
      .cb1    (cb1[g]),
      .prod_r (prod[g]),
      .res_r  (lres[g]),
      .ov_r   (lov[g])
    );
  end

  // broadcast max / min and equality on the raw inputs
  always_comb begin
    mx01 = (in_ax > in_ay) ? in_ax : in_ay;
    mx23 = (in_az > in_aw) ? in_az : in_aw;
    mn01 = (in_ax < in_ay) ? in_ax : in_ay;
    mn23 = (in_az < in_aw) ? in_az : in_aw;
    mx   = (mx01 > mx23) ? mx01 : mx23;
    mn   = (mn01 < mn23) ? mn01 : mn23;
    front_in.op  = op_in;
    front_in.a   = {in_aw, in_az, in_ay, in_ax};
    front_in.s   = in_scale;
    front_in.mm  = (op_in == OP_MIN) ? mn : mx;
    front_in.cmp = ({in_ax, in_ay, in_az, in_aw} == {in_bx, in_by, in_bz, in_bw});
  end

  // stage 1 and 2 context, pairwise product sums
  always_ff @(posedge clk) begin
    if (adv) begin
      front1_r <= front_in;
      front2_r <= front1_r;
      p01_r    <= 67'(prod[0]) + 67'(prod[1]);
      p23_r    <= 67'(prod[2]) + 67'(prod[3]);
    end
  end

  // merge: total sum, dot and squared length, result vector select
  always_comb begin
    total   = 68'(p01_r) + 68'(p23_r);
    dot_rnd = (total + HALF) >>> FRAC_BITS;
    dot_sat = sat_word(dot_rnd);
    sq3     = (total[67:64] != 4'd0) ? '1 : total[63:0];

    ctx3.op  = front2_r.op;
    ctx3.s   = front2_r.s;
    ctx3.vec = '0;
    ctx3.sc  = '0;
    ctx3.cmp = 1'b0;
    ctx3.ov  = 1'b0;
    unique case (front2_r.op)
      OP_ADD, OP_SUB, OP_NEG, OP_SCALE, OP_CROSS, OP_LERP: begin
        for (int i = 0; i < LANES; i++) ctx3.vec[i] = lres[i];
        ctx3.ov = lov[0] | lov[1] | lov[2] | lov[3];
      end
      OP_MAX, OP_MIN: begin
        for (int i = 0; i < LANES; i++) ctx3.vec[i] = front2_r.mm;
      end
      OP_DIV, OP_NORM: ctx3.vec = front2_r.a;
      OP_EQ:           ctx3.cmp = front2_r.cmp;
      OP_NE:           ctx3.cmp = !front2_r.cmp;
      OP_DOT, OP_LENSQ: begin
        ctx3.sc = dot_sat[31:0];
        ctx3.ov = dot_sat[32];
      end
      default: ctx3.vec = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx3_r <= ctx3;
      sq3_r  <= sq3;
    end
  end

  // square root chain
  assign ctx_s[0] = ctx3_r;
  assign rem_s[0] = sq3_r;
  assign res_s[0] = '0;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    vfa_sqrt_step #(
      .STEP (k)
    ) u_sqrt (
      .clk   (clk),
      .en    (adv),
      .ctx_i (ctx_s[k]),
      .rem_i (rem_s[k]),
      .res_i (res_s[k]),
      .ctx_r (ctx_s[k+1]),
      .rem_r (rem_s[k+1]),
      .res_r (res_s[k+1])
    );
  end

  // length rounding and divider setup
  always_comb begin
    ctx_d = ctx_s[SQ_STEPS];
    len   = res_s[SQ_STEPS][32:0] + 33'(rem_s[SQ_STEPS] > res_s[SQ_STEPS]);
    if (ctx_d.op == OP_LEN) begin
      if (len > 33'(WORD_MAX)) begin
        ctx_d.sc = WORD_MAX;
        ctx_d.ov = 1'b1;
      end else begin
        ctx_d.sc = len[31:0];
      end
    end
    dmag = (ctx_d.op == OP_DIV) ? {1'b0, abs_word(ctx_d.s)} : len;
    amag = '0;
    for (int i = 0; i < LANES; i++) begin
      amag          = abs_word(ctx_d.vec[i]);
      dl_d[i].rem   = 64'(amag) << FRAC_BITS;
      dl_d[i].d     = dmag;
      dl_d[i].q     = '0;
      dl_d[i].neg   = ctx_d.vec[i][31] ^ ((ctx_d.op == OP_DIV) & ctx_d.s[31]);
      dl_d[i].dz    = (dmag == '0);
      dl_d[i].big   = {1'b0, dl_d[i].rem} >= {dmag, 32'd0};
      dl_d[i].apos  = !ctx_d.vec[i][31] && (ctx_d.vec[i] != '0);
      dl_d[i].aneg  = ctx_d.vec[i][31];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx_v[0] <= ctx_d;
      dl_v[0]  <= dl_d;
    end
  end

  // divider chain
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    vfa_div_step #(
      .STEP (k)
    ) u_div (
      .clk   (clk),
      .en    (adv),
      .ctx_i (ctx_v[k]),
      .dl_i  (dl_v[k]),
      .ctx_r (ctx_v[k+1]),
      .dl_r  (dl_v[k+1])
    );
  end

  assign ctx_e = ctx_v[DIV_STEPS];
  assign dl_e  = dl_v[DIV_STEPS];

  // quotient sign, saturation and divide-by-zero handling
  always_comb begin
    fv  = ctx_e.vec;
    fov = ctx_e.ov;
    if (ctx_e.op == OP_DIV || ctx_e.op == OP_NORM) begin
      for (int i = 0; i < LANES; i++) begin
        priority if (dl_e[i].dz) begin
          if (ctx_e.op == OP_DIV) begin
            fv[i] = dl_e[i].apos ? WORD_MAX : (dl_e[i].aneg ? WORD_MIN : '0);
          end else begin
            fv[i] = '0;
          end
        end else if (dl_e[i].big) begin
          fv[i] = dl_e[i].neg ? WORD_MIN : WORD_MAX;
          fov   = 1'b1;
        end else if (!dl_e[i].neg) begin
          if (dl_e[i].q[31]) begin
            fv[i] = WORD_MAX;
            fov   = 1'b1;
          end else begin
            fv[i] = dl_e[i].q;
          end
        end else begin
          if (dl_e[i].q > WORD_MIN) begin
            fv[i] = WORD_MIN;
            fov   = 1'b1;
          end else begin
            fv[i] = 32'd0 - dl_e[i].q;
          end
        end
      end
      if (ctx_e.op == OP_DIV && dl_e[0].dz) fov = 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_vec_r <= fv;
      out_sc_r  <= ctx_e.sc;
      out_cmp_r <= ctx_e.cmp;
      out_ov_r  <= fov;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_rx           = out_vec_r[0];
  assign out_ry           = out_vec_r[1];
  assign out_rz           = out_vec_r[2];
  assign out_rw           = out_vec_r[3];
  assign out_scalar_out   = out_sc_r;
  assign out_compare_true = out_cmp_r;
  assign out_overflow     = out_ov_r;

endmodule

[rtl/vfa_lane.sv]
// ----------------------------------------------------------------------------
// vfa_lane
// One vector lane: operand select, multiply and saturating add, subtract and
// negate in the first stage, then scale, cross and lerp with rounding and
// saturation in the second stage.
// ----------------------------------------------------------------------------
module vfa_lane
  import vfa_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                en,
  input  op_t                 op,
  input  logic signed [31:0]  a,
  input  logic signed [31:0]  b,
  input  logic signed [31:0]  s,
  input  logic signed [31:0]  ca0,
  input  logic signed [31:0]  cb0,
  input  logic signed [31:0]  ca1,
  input  logic signed [31:0]  cb1,
  output logic signed [65:0]  prod_r,
  output logic        [31:0]  res_r,
  output logic                ov_r
);

  localparam logic signed [67:0] HALF = 68'sd1 <<< (FRAC_BITS - 1);

  logic signed [32:0] x, y;
  logic signed [65:0] m0;
  logic signed [63:0] m1;
  logic        [32:0] smp;
  op_t                op1_r;
  logic signed [63:0] m1_r;
  logic signed [31:0] a1_r;
  logic        [32:0] smp_r;
  logic signed [67:0] t;
  logic signed [67:0] t_rnd;
  logic        [32:0] res_nxt;

  // multiplier operand select
  always_comb begin
    x = '0;
    y = '0;
    unique case (op)
      OP_SCALE: begin
        x = 33'(a);
        y = 33'(s);
      end
      OP_DOT: begin
        x = 33'(a);
        y = 33'(b);
      end
      OP_LEN, OP_LENSQ, OP_NORM: begin
        x = 33'(a);
        y = 33'(a);
      end
      OP_CROSS: begin
        x = 33'(ca0);
        y = 33'(cb0);
      end
      OP_LERP: begin
        x = 33'(b) - 33'(a);
        y = 33'(s);
      end
      default: begin
        x = '0;
        y = '0;
      end
    endcase
  end

  assign m0 = x * y;
  assign m1 = ca1 * cb1;

  // add, subtract and negate saturate in the first stage
  always_comb begin
    unique case (op)
      OP_ADD:  smp = sat_word(68'(a) + 68'(b));
      OP_SUB:  smp = sat_word(68'(a) - 68'(b));
      OP_NEG:  smp = sat_word(68'sd0 - 68'(a));
      default: smp = '0;
    endcase
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (en) begin
      op1_r  <= op;
      prod_r <= m0;
      m1_r   <= m1;
      a1_r   <= a;
      smp_r  <= smp;
    end
  end

  // rounding sum of the lane terms
  always_comb begin
    unique case (op1_r)
      OP_CROSS: t = 68'(prod_r) - 68'(m1_r);
      OP_LERP:  t = (68'(a1_r) <<< FRAC_BITS) + 68'(prod_r);
      default:  t = 68'(prod_r);
    endcase
    t_rnd = (t + HALF) >>> FRAC_BITS;
    unique case (op1_r)
      OP_ADD, OP_SUB, OP_NEG:       res_nxt = smp_r;
      OP_SCALE, OP_CROSS, OP_LERP:  res_nxt = sat_word(t_rnd);
      default:                      res_nxt = '0;
    endcase
  end

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt[31:0];
      ov_r  <= res_nxt[32];
    end
  end

endmodule

[rtl/vfa_sqrt_step.sv]
// ----------------------------------------------------------------------------
// vfa_sqrt_step
// One stage of the digit-by-digit integer square root: settles one result
// bit of the 64-bit radicand and carries the item context along.
// ----------------------------------------------------------------------------
module vfa_sqrt_step
  import vfa_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic        clk,
  input  logic        en,
  input  ctx_t        ctx_i,
  input  logic [63:0] rem_i,
  input  logic [63:0] res_i,
  output ctx_t        ctx_r,
  output logic [63:0] rem_r,
  output logic [63:0] res_r
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

  logic [64:0] trial;
  logic [63:0] rem_nxt, res_nxt;

  // trial subtract of res + bit
  always_comb begin
    trial = {1'b0, res_i} + {1'b0, BIT};
    if ({1'b0, rem_i} >= trial) begin
      rem_nxt = rem_i - trial[63:0];
      res_nxt = (res_i >> 1) + BIT;
    end else begin
      rem_nxt = rem_i;
      res_nxt = res_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r <= ctx_i;
      rem_r <= rem_nxt;
      res_r <= res_nxt;
    end
  end

endmodule

[rtl/vfa_div_step.sv]
// ----------------------------------------------------------------------------
// vfa_div_step
// One stage of the four-lane restoring divider: each lane settles one
// quotient bit, the item context rides along.
// ----------------------------------------------------------------------------
module vfa_div_step
  import vfa_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic  clk,
  input  logic  en,
  input  ctx_t  ctx_i,
  input  dvec_t dl_i,
  output ctx_t  ctx_r,
  output dvec_t dl_r
);

  localparam int BITPOS = DIV_STEPS - 1 - STEP;

  dvec_t       dl_nxt;
  logic [63:0] dsub [LANES];

  // compare and subtract the shifted divisor in every lane
  always_comb begin
    dl_nxt = dl_i;
    for (int i = 0; i < LANES; i++) begin
      dsub[i] = {31'd0, dl_i[i].d} << BITPOS;
      if (dl_i[i].rem >= dsub[i]) begin
        dl_nxt[i].rem       = dl_i[i].rem - dsub[i];
        dl_nxt[i].q[BITPOS] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r <= ctx_i;
      dl_r  <= dl_nxt;
    end
  end

endmodule
